[rtl/ncs_pkg.sv]
// ============================================================================
// ncs_pkg
// Shared types and constants for the nested comment scanner.
// ============================================================================
`default_nettype none

package ncs_pkg;

    localparam int DEPTH_BITS_DEF = 16;
    localparam int LEN_BITS_DEF   = 24;

    localparam int SCALAR_W = 21;
    localparam int OUT_LEN_W = 24;

    localparam logic [SCALAR_W-1:0] CH_SLASH = 21'h00002F;
    localparam logic [SCALAR_W-1:0] CH_STAR  = 21'h00002A;
    localparam logic [SCALAR_W-1:0] CH_BANG  = 21'h000021;
    localparam logic [SCALAR_W-1:0] CH_SPACE = 21'h000020;
    localparam logic [SCALAR_W-1:0] CH_LF    = 21'h00000A;

    // Scan modes. The last code names no scan kind and is refused.
    localparam logic [1:0] MODE_LINE  = 2'd0;
    localparam logic [1:0] MODE_DOC   = 2'd1;
    localparam logic [1:0] MODE_BLOCK = 2'd2;
    localparam logic [1:0] MODE_NONE  = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_OPENER = 2'd1;
    localparam logic [1:0] ST_UNTERM    = 2'd2;
    localparam logic [1:0] ST_OVERFLOW  = 2'd3;

    // Comment kinds.
    localparam logic [1:0] CK_LINE       = 2'd0;
    localparam logic [1:0] CK_LINE_DOC   = 2'd1;
    localparam logic [1:0] CK_MODULE_DOC = 2'd2;
    localparam logic [1:0] CK_BLOCK      = 2'd3;

    localparam logic [2:0] BODY_OFF_PLAIN = 3'd3;
    localparam logic [2:0] BODY_OFF_SPACE = 3'd4;

    typedef struct packed {
        logic                eot;
        logic [SCALAR_W-1:0] scalar;
        logic                first;
        logic [1:0]          mode;
    } t_item;

    typedef struct packed {
        logic [1:0]           status;
        logic [1:0]           comment_kind;
        logic [OUT_LEN_W-1:0] length;
        logic [2:0]           body_offset;
        logic [OUT_LEN_W-1:0] body_length;
    } t_result;

endpackage

`default_nettype wire

[rtl/ncs_in_reg.sv]
// ============================================================================
// ncs_in_reg
// Input register stage holding one accepted word for the scan core.
// ============================================================================
`default_nettype none

module ncs_in_reg
    import ncs_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_ready,
    input  wire t_item i_item,
    input  wire logic  i_take,
    output logic       o_valid,
    output t_item      o_item
);

    logic  r_valid;
    t_item r_item;

    // The stage refills in the same cycle that the core consumes it.
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

[rtl/ncs_core.sv]
// ============================================================================
// ncs_core
// Scan state and the single-step update applied to each registered word.
// ============================================================================
`default_nettype none

module ncs_core
    import ncs_pkg::*;
#(
    parameter int DEPTH_BITS = DEPTH_BITS_DEF,
    parameter int LEN_BITS   = LEN_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_item_valid,
    input  wire t_item i_item,
    input  wire logic  i_out_free,
    output logic       o_take,
    output logic       o_res_valid,
    output t_result    o_res
);

    logic                  r_active, n_active;
    logic [1:0]            r_mode, n_mode;
    logic [LEN_BITS-1:0]   r_pos, n_pos;
    logic                  r_pslash, n_pslash;
    logic                  r_pstar, n_pstar;
    logic [DEPTH_BITS-1:0] r_depth, n_depth;
    logic [1:0]            r_doc, n_doc;
    logic                  r_space, n_space;

    // Working copy of the state that a step operates on.
    logic [1:0]            e_mode;
    logic [LEN_BITS-1:0]   e_pos;
    logic                  e_pslash;
    logic                  e_pstar;
    logic [DEPTH_BITS-1:0] e_depth;
    logic [LEN_BITS-1:0]   e_pos_inc;
    logic                  do_step;

    logic                  emit;
    logic [1:0]            res_status;
    logic [1:0]            res_kind;
    logic [LEN_BITS-1:0]   res_len;
    logic [2:0]            res_off;
    logic [LEN_BITS-1:0]   res_blen;
    logic [OUT_LEN_W-1:0]  len_out;
    logic [OUT_LEN_W-1:0]  blen_out;
    logic                  line_done;

    logic [SCALAR_W-1:0]   c;

    assign o_take = i_item_valid && i_out_free;
    assign c      = i_item.scalar;

    // A line or doc scan is complete once its opener (two or three scalars) is in.
    assign line_done = (r_mode == MODE_DOC) ? (r_pos >= LEN_BITS'(3))
                                            : (r_pos >= LEN_BITS'(2));

    always_comb begin
        n_active = r_active;
        n_mode   = r_mode;
        n_pos    = r_pos;
        n_pslash = r_pslash;
        n_pstar  = r_pstar;
        n_depth  = r_depth;
        n_doc    = r_doc;
        n_space  = r_space;

        emit       = 1'b0;
        res_status = ST_OK;
        res_kind   = CK_LINE;
        res_len    = '0;
        res_off    = '0;
        res_blen   = '0;

        do_step  = 1'b0;
        e_mode   = r_mode;
        e_pos    = r_pos;
        e_pslash = r_pslash;
        e_pstar  = r_pstar;
        e_depth  = r_depth;

        if (i_item.eot) begin
            if (r_active) begin
                emit = 1'b1;
                if (r_mode == MODE_BLOCK) begin
                    if (r_pos >= LEN_BITS'(2)) begin
                        res_status = ST_UNTERM;
                        res_kind   = CK_BLOCK;
                        res_len    = r_pos;
                    end else begin
                        res_status = ST_NO_OPENER;
                    end
                end else if (line_done) begin
                    res_len = r_pos;
                    if (r_mode == MODE_DOC) begin
                        res_kind = r_doc;
                        res_off  = r_space ? BODY_OFF_SPACE : BODY_OFF_PLAIN;
                        res_blen = r_pos - LEN_BITS'(res_off);
                    end
                end else begin
                    res_status = ST_NO_OPENER;
                end
            end else if (i_item.first) begin
                emit       = 1'b1;
                res_status = ST_NO_OPENER;
            end
        end else if (r_active && r_mode != MODE_BLOCK && c == CH_LF && line_done) begin
            emit    = 1'b1;
            res_len = r_pos;
            if (r_mode == MODE_DOC) begin
                res_kind = r_doc;
                res_off  = r_space ? BODY_OFF_SPACE : BODY_OFF_PLAIN;
                res_blen = r_pos - LEN_BITS'(res_off);
            end
        end else if (i_item.first) begin
            if (i_item.mode == MODE_NONE) begin
                emit       = 1'b1;
                res_status = ST_NO_OPENER;
            end else begin
                // A restart drops whatever scan was running.
                do_step  = 1'b1;
                e_mode   = i_item.mode;
                e_pos    = '0;
                e_pslash = 1'b0;
                e_pstar  = 1'b0;
                e_depth  = '0;
                n_doc    = '0;
                n_space  = 1'b0;
            end
        end else if (r_active) begin
            do_step = 1'b1;
        end

        e_pos_inc = (&e_pos) ? e_pos : e_pos + LEN_BITS'(1);

        if (do_step) begin
            n_active = 1'b1;
            n_mode   = e_mode;
            n_pos    = e_pos_inc;
            n_pslash = e_pslash;
            n_pstar  = e_pstar;
            n_depth  = e_depth;
            if (e_mode == MODE_BLOCK) begin
                if (e_pos == '0) begin
                    if (c != CH_SLASH) begin
                        emit       = 1'b1;
                        res_status = ST_NO_OPENER;
                    end
                end else if (e_pos == LEN_BITS'(1)) begin
                    if (c != CH_STAR) begin
                        emit       = 1'b1;
                        res_status = ST_NO_OPENER;
                    end else begin
                        n_depth  = DEPTH_BITS'(1);
                        n_pslash = 1'b0;
                        n_pstar  = 1'b0;
                    end
                end else if (e_pslash && c == CH_STAR) begin
                    n_pslash = 1'b0;
                    if (&e_depth) begin
                        emit       = 1'b1;
                        res_status = ST_OVERFLOW;
                        res_kind   = CK_BLOCK;
                        res_len    = e_pos_inc;
                    end else begin
                        n_depth = e_depth + DEPTH_BITS'(1);
                    end
                end else if (e_pstar && c == CH_SLASH) begin
                    n_pstar = 1'b0;
                    if (e_depth <= DEPTH_BITS'(1)) begin
                        emit     = 1'b1;
                        res_kind = CK_BLOCK;
                        res_len  = e_pos_inc;
                    end else begin
                        n_depth = e_depth - DEPTH_BITS'(1);
                    end
                end else begin
                    n_pslash = (c == CH_SLASH);
                    n_pstar  = (c == CH_STAR);
                end
            end else begin
                if (e_pos < LEN_BITS'(2)) begin
                    if (c != CH_SLASH) begin
                        emit       = 1'b1;
                        res_status = ST_NO_OPENER;
                    end
                end else if (e_mode == MODE_DOC && e_pos == LEN_BITS'(2)) begin
                    if (c == CH_SLASH) begin
                        n_doc = CK_LINE_DOC;
                    end else if (c == CH_BANG) begin
                        n_doc = CK_MODULE_DOC;
                    end else begin
                        emit       = 1'b1;
                        res_status = ST_NO_OPENER;
                    end
                end else if (e_mode == MODE_DOC && e_pos == LEN_BITS'(3) &&
                             c == CH_SPACE) begin
                    n_space = 1'b1;
                end
            end
        end

        // Every result closes the scan.
        if (emit) begin
            n_active = 1'b0;
            n_mode   = '0;
            n_pos    = '0;
            n_pslash = 1'b0;
            n_pstar  = 1'b0;
            n_depth  = '0;
            n_doc    = '0;
            n_space  = 1'b0;
        end
    end

    generate
        if (LEN_BITS >= OUT_LEN_W) begin : g_len_trunc
            assign len_out  = res_len[OUT_LEN_W-1:0];
            assign blen_out = res_blen[OUT_LEN_W-1:0];
        end else begin : g_len_ext
            assign len_out  = {{(OUT_LEN_W-LEN_BITS){1'b0}}, res_len};
            assign blen_out = {{(OUT_LEN_W-LEN_BITS){1'b0}}, res_blen};
        end
    endgenerate

    assign o_res_valid        = o_take && emit;
    assign o_res.status       = res_status;
    assign o_res.comment_kind = res_kind;
    assign o_res.length       = len_out;
    assign o_res.body_offset  = res_off;
    assign o_res.body_length  = blen_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_mode   <= '0;
            r_pos    <= '0;
            r_pslash <= 1'b0;
            r_pstar  <= 1'b0;
            r_depth  <= '0;
            r_doc    <= '0;
            r_space  <= 1'b0;
        end else if (o_take) begin
            r_active <= n_active;
            r_mode   <= n_mode;
            r_pos    <= n_pos;
            r_pslash <= n_pslash;
            r_pstar  <= n_pstar;
            r_depth  <= n_depth;
            r_doc    <= n_doc;
            r_space  <= n_space;
        end
    end

endmodule

`default_nettype wire

[rtl/ncs_out_reg.sv]
// ============================================================================
// ncs_out_reg
// Result register that holds a finished word until the receiver takes it.
// ============================================================================
`default_nettype none

module ncs_out_reg
    import ncs_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_result i_res,
    input  wire logic    i_ready,
    output logic         o_free,
    output logic         o_valid,
    output t_result      o_res
);

    logic    r_valid;
    t_result r_res;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

`default_nettype wire

[rtl/nested_comment_scanner_top.sv]
// ============================================================================
// nested_comment_scanner_top
// Streaming scanner that measures line, doc and nested block comments.
// ============================================================================
// The slave channel takes one source word per cycle while s_tready is high:
// a Unicode scalar, or an end-of-text marker, with a first flag that starts a
// scan and a mode that picks line, doc or block scanning. The master channel
// delivers one result word whenever a scan ends: status, comment kind, length
// and, for doc comments, the body offset and body length.
//
// Each accepted word sits in the input register until the core takes it, is
// applied to the scan state by a single step of compare and counter logic,
// and any result is captured in the output register as the word is taken.
// A result thus passes the input register and then the output register
// before the receiver can take it on the master side. One word is accepted
// per cycle, sustained, as long as the receiver takes results; the scan
// state update is the only loop.
//
// Reset (synchronous, active low) empties both registers and clears the scan
// state. When the receiver stalls, the pending result holds on the master
// side, one more word may be taken into the input register, and then
// s_tready drops until the result is taken.
// ============================================================================
`default_nettype none

module nested_comment_scanner_top
    import ncs_pkg::*;
#(
    parameter int DEPTH_BITS = DEPTH_BITS_DEF,
    parameter int LEN_BITS   = LEN_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    // tdata: scalar [20:0], zero [23:21]
    input  wire logic [23:0] s_tdata,
    // tuser: kind [0], first [1], mode [3:2]
    input  wire logic [3:0]  s_tuser,

    output logic             m_tvalid,
    input  wire logic        m_tready,
    // tdata: status [1:0], length [25:2], body_offset [28:26],
    //        body_length [52:29], zero [55:53]
    output logic [55:0]      m_tdata,
    // tuser: comment_kind [1:0]
    output logic [1:0]       m_tuser
);

    t_item   in_item;
    t_item   reg_item;
    logic    reg_valid;
    logic    take;
    logic    out_free;
    logic    res_valid;
    t_result res;
    t_result out_res;

    assign in_item.eot    = s_tuser[0];
    assign in_item.scalar = s_tdata[SCALAR_W-1:0];
    assign in_item.first  = s_tuser[1];
    assign in_item.mode   = s_tuser[3:2];

    ncs_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_tvalid),
        .o_ready (s_tready),
        .i_item  (in_item),
        .i_take  (take),
        .o_valid (reg_valid),
        .o_item  (reg_item)
    );

    ncs_core #(
        .DEPTH_BITS (DEPTH_BITS),
        .LEN_BITS   (LEN_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (reg_valid),
        .i_item       (reg_item),
        .i_out_free   (out_free),
        .o_take       (take),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    ncs_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_valid),
        .i_res   (res),
        .i_ready (m_tready),
        .o_free  (out_free),
        .o_valid (m_tvalid),
        .o_res   (out_res)
    );

    assign m_tdata = {3'b000, out_res.body_length, out_res.body_offset,
                      out_res.length, out_res.status};
    assign m_tuser = out_res.comment_kind;

endmodule

`default_nettype wire

[dv/nested_comment_checker.sv]
`timescale 1ns / 1ps
// ============================================================================
// nested_comment_checker
// Watches both stream channels of the comment scanner and checks its reports.
// ============================================================================
// Every accepted source word runs through a cycle-free model of the scanner
// kept here. Each report that the model produces is queued and compared,
// field by field, with the next report word the scanner hands over.
// ============================================================================

module nested_comment_checker
    import ncs_pkg::*;
#(
    parameter int DEPTH_BITS = DEPTH_BITS_DEF,
    parameter int LEN_BITS   = LEN_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_in_tvalid,
    input  wire logic        i_in_tready,
    // tdata: scalar [20:0], zero [23:21]
    input  wire logic [23:0] i_in_tdata,
    // tuser: kind [0], first [1], mode [3:2]
    input  wire logic [3:0]  i_in_tuser,

    input  wire logic        i_out_tvalid,
    input  wire logic        i_out_tready,
    // tdata: status [1:0], length [25:2], body_offset [28:26],
    //        body_length [52:29], zero [55:53]
    input  wire logic [55:0] i_out_tdata,
    // tuser: comment_kind [1:0]
    input  wire logic [1:0]  i_out_tuser,

    output int               o_fail_count,
    output int               o_pending
);

    localparam logic [63:0] DEPTH_LIMIT = (64'd1 << DEPTH_BITS) - 64'd1;
    localparam logic [63:0] LEN_LIMIT   = (64'd1 << LEN_BITS) - 64'd1;

    // Scan state of the model.
    logic        in_comment;
    logic [1:0]  comment_mode;
    logic [63:0] scalars_seen;
    logic        prev_slash;
    logic        prev_star;
    logic [63:0] nesting;
    logic [1:0]  doc_sort;
    logic        space_seen;

    t_result comment_reports_q[$];
    int      mismatches = 0;

    function automatic void drop_comment();
        in_comment   = 1'b0;
        comment_mode = MODE_LINE;
        scalars_seen = '0;
        prev_slash   = 1'b0;
        prev_star    = 1'b0;
        nesting      = '0;
        doc_sort     = CK_LINE;
        space_seen   = 1'b0;
    endfunction

    function automatic void count_scalar();
        if (scalars_seen < LEN_LIMIT) scalars_seen++;
    endfunction

    function automatic bit close_comment(input logic [1:0] st, input logic [1:0] ck,
                                         input logic [63:0] len, input logic [2:0] off,
                                         input logic [63:0] blen, output t_result r);
        r.status       = st;
        r.comment_kind = ck;
        r.length       = len[OUT_LEN_W-1:0];
        r.body_offset  = off;
        r.body_length  = blen[OUT_LEN_W-1:0];
        drop_comment();
        return 1'b1;
    endfunction

    function automatic bit refuse_comment(output t_result r);
        return close_comment(ST_NO_OPENER, CK_LINE, 64'd0, 3'd0, 64'd0, r);
    endfunction

    // Scalars that a line or doc opener takes before the comment is valid.
    function automatic logic [63:0] opener_len();
        return (comment_mode == MODE_DOC) ? 64'd3 : 64'd2;
    endfunction

    function automatic bit end_line_comment(output t_result r);
        logic [2:0] off;
        if (comment_mode == MODE_DOC) begin
            off = space_seen ? BODY_OFF_SPACE : BODY_OFF_PLAIN;
            return close_comment(ST_OK, doc_sort, scalars_seen, off,
                                 scalars_seen - 64'(off), r);
        end
        return close_comment(ST_OK, CK_LINE, scalars_seen, 3'd0, 64'd0, r);
    endfunction

    function automatic bit step_comment_body(input logic [SCALAR_W-1:0] ch,
                                             output t_result r);
        if (comment_mode == MODE_BLOCK) begin
            if (scalars_seen == 64'd0) begin
                if (ch != CH_SLASH) return refuse_comment(r);
                count_scalar();
                return 1'b0;
            end
            if (scalars_seen == 64'd1) begin
                if (ch != CH_STAR) return refuse_comment(r);
                nesting    = 64'd1;
                prev_slash = 1'b0;
                prev_star  = 1'b0;
                count_scalar();
                return 1'b0;
            end
            count_scalar();
            // Pairs are taken left to right and never share a scalar.
            if (prev_slash && ch == CH_STAR) begin
                prev_slash = 1'b0;
                if (nesting >= DEPTH_LIMIT)
                    return close_comment(ST_OVERFLOW, CK_BLOCK, scalars_seen, 3'd0, 64'd0, r);
                nesting++;
                return 1'b0;
            end
            if (prev_star && ch == CH_SLASH) begin
                prev_star = 1'b0;
                if (nesting <= 64'd1)
                    return close_comment(ST_OK, CK_BLOCK, scalars_seen, 3'd0, 64'd0, r);
                nesting--;
                return 1'b0;
            end
            prev_slash = (ch == CH_SLASH);
            prev_star  = (ch == CH_STAR);
            return 1'b0;
        end
        if (scalars_seen < 64'd2) begin
            if (ch != CH_SLASH) return refuse_comment(r);
        end else if (comment_mode == MODE_DOC && scalars_seen == 64'd2) begin
            if (ch == CH_SLASH) doc_sort = CK_LINE_DOC;
            else if (ch == CH_BANG) doc_sort = CK_MODULE_DOC;
            else return refuse_comment(r);
        end else if (comment_mode == MODE_DOC && scalars_seen == 64'd3 && ch == CH_SPACE) begin
            space_seen = 1'b1;
        end
        count_scalar();
        return 1'b0;
    endfunction

    // Applies one source word; returns 1 when it ends a scan with a report.
    function automatic bit predict_comment_report(input t_item w, output t_result r);
        r = '0;
        if (w.eot) begin
            if (in_comment) begin
                if (comment_mode == MODE_BLOCK) begin
                    if (scalars_seen >= 64'd2)
                        return close_comment(ST_UNTERM, CK_BLOCK, scalars_seen, 3'd0, 64'd0, r);
                    return refuse_comment(r);
                end
                if (scalars_seen >= opener_len()) return end_line_comment(r);
                return refuse_comment(r);
            end
            if (w.first) return refuse_comment(r);
            return 1'b0;
        end
        // A line feed past the opener ends a line scan, whatever first says.
        if (in_comment && comment_mode != MODE_BLOCK && w.scalar == CH_LF &&
            scalars_seen >= opener_len())
            return end_line_comment(r);
        if (w.first) begin
            drop_comment();
            if (!(w.mode == MODE_LINE || w.mode == MODE_DOC || w.mode == MODE_BLOCK))
                return refuse_comment(r);
            in_comment   = 1'b1;
            comment_mode = w.mode;
            return step_comment_body(w.scalar, r);
        end
        if (in_comment) return step_comment_body(w.scalar, r);
        return 1'b0;
    endfunction

    task automatic compare_field(input string what, input logic [23:0] want,
                                 input logic [23:0] got, inout bit bad);
        if (got !== want) begin
            $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
            bad = 1'b1;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_result got;
        t_result want;
        t_result guess;
        t_item   w;
        bit      bad;
        if (!i_rst_n) begin
            drop_comment();
            comment_reports_q.delete();
        end else begin
            if (i_out_tvalid && i_out_tready) begin
                got.status       = i_out_tdata[1:0];
                got.length       = i_out_tdata[25:2];
                got.body_offset  = i_out_tdata[28:26];
                got.body_length  = i_out_tdata[52:29];
                got.comment_kind = i_out_tuser;
                if (comment_reports_q.size() == 0) begin
                    $display("%0t: report word expected none, got tdata %h tuser %h",
                             $time, i_out_tdata, i_out_tuser);
                    mismatches++;
                end else begin
                    want = comment_reports_q.pop_front();
                    bad  = 1'b0;
                    compare_field("status", want.status, got.status, bad);
                    compare_field("comment_kind", want.comment_kind, got.comment_kind, bad);
                    compare_field("length", want.length, got.length, bad);
                    compare_field("body_offset", want.body_offset, got.body_offset, bad);
                    compare_field("body_length", want.body_length, got.body_length, bad);
                    if (bad) mismatches++;
                end
            end
            if (i_in_tvalid && i_in_tready) begin
                w.eot    = i_in_tuser[0];
                w.scalar = i_in_tdata[SCALAR_W-1:0];
                w.first  = i_in_tuser[1];
                w.mode   = i_in_tuser[3:2];
                if (predict_comment_report(w, guess)) comment_reports_q.push_back(guess);
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= comment_reports_q.size();
    end

endmodule

[dv/tb_nested_comment_scanner_top.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_nested_comment_scanner_top
// Stimulus and verdict for the nested comment scanner.
// ============================================================================
// The scanner is built with its default depth and length widths. A directed
// list walks every scan kind and its corner cases, a long receiver hold
// fills the pipeline, and then a mostly well-formed random text runs with
// random gaps on both channels. The checker beside the scanner predicts and
// compares every report word.
// ============================================================================

module tb_nested_comment_scanner_top
    import ncs_pkg::*;
;

    localparam int TB_DEPTH_BITS = DEPTH_BITS_DEF;
    localparam int TB_LEN_BITS   = LEN_BITS_DEF;

    localparam int RANDOM_WORDS = 500;
    // The last stretch of the random text runs with no gaps on either side.
    localparam int QUIET_TAIL   = 120;
    localparam int HOLD_CYCLES  = 120;
    // Reports pass both scanner registers before they can be taken; this covers stragglers.
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 200000;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic [3:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic [1:0]  m_tuser;

    int   fail_count;
    int   pending_reports;
    int   cycle_count;
    int   words_sent = 0;
    logic idle_en    = 1'b1;
    logic hold_req   = 1'b0;

    always #6 i_clk = ~i_clk;

    nested_comment_scanner_top #(
        .DEPTH_BITS(TB_DEPTH_BITS),
        .LEN_BITS  (TB_LEN_BITS)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    nested_comment_checker #(
        .DEPTH_BITS(TB_DEPTH_BITS),
        .LEN_BITS  (TB_LEN_BITS)
    ) i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_tvalid (s_tvalid),
        .i_in_tready (s_tready),
        .i_in_tdata  (s_tdata),
        .i_in_tuser  (s_tuser),
        .i_out_tvalid(m_tvalid),
        .i_out_tready(m_tready),
        .i_out_tdata (m_tdata),
        .i_out_tuser (m_tuser),
        .o_fail_count(fail_count),
        .o_pending   (pending_reports)
    );

    // Offers one source word and returns at the falling edge after it was
    // taken. An optional gap with tvalid low comes first; tvalid is written
    // only once per falling edge, so back-to-back words keep it high.
    task automatic send_word(input bit eot, input logic [SCALAR_W-1:0] ch,
                             input bit first, input logic [1:0] mode);
        int gap;
        gap = 0;
        if (idle_en && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 14);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tdata  <= {3'b000, ch};
        s_tuser  <= {mode, first, eot};
        s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_tready);
        @(negedge i_clk);
        words_sent++;
    endtask

    // Sends a text with first set on its opening character.
    task automatic send_text(input string txt, input logic [1:0] mode);
        for (int i = 0; i < txt.len(); i++)
            send_word(1'b0, SCALAR_W'(txt[i]), i == 0, mode);
    endtask

    function automatic logic [1:0] any_mode();
        return 2'($urandom_range(0, 3));
    endfunction

    function automatic logic [SCALAR_W-1:0] any_scalar();
        return SCALAR_W'($urandom_range(0, 21'h10FFFF));
    endfunction

    function automatic bit any_flag();
        return 1'($urandom_range(0, 1));
    endfunction

    // Comment body characters lean hard on the ones the scanner reacts to.
    function automatic logic [SCALAR_W-1:0] body_char(input bit lf_ok);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 25) return CH_SLASH;
        if (roll < 45) return CH_STAR;
        if (roll < 55) return CH_SPACE;
        if (roll < 60) return CH_BANG;
        if (roll < 64 && lf_ok) return CH_LF;
        if (roll < 67) return 21'h10FFFF;
        return any_scalar();
    endfunction

    // One well-formed comment with random content and a random ending. A
    // long body keeps a doc scan open for a few hundred scalars.
    task automatic send_random_comment(input bit long_body);
        logic [1:0] m;
        int         n;
        int         roll;
        m = long_body ? MODE_DOC : 2'($urandom_range(0, 2));
        send_word(1'b0, CH_SLASH, 1'b1, m);
        send_word(1'b0, (m == MODE_BLOCK) ? CH_STAR : CH_SLASH, 1'b0, any_mode());
        if (m == MODE_DOC) begin
            send_word(1'b0, $urandom_range(0, 1) ? CH_SLASH : CH_BANG, 1'b0, any_mode());
            if ($urandom_range(0, 1)) send_word(1'b0, CH_SPACE, 1'b0, any_mode());
        end
        n = long_body ? $urandom_range(260, 300) : $urandom_range(0, 10);
        repeat (n) send_word(1'b0, body_char(m == MODE_BLOCK), 1'b0, any_mode());
        roll = $urandom_range(0, 99);
        if (m == MODE_BLOCK) begin
            if (roll < 60) begin
                repeat ($urandom_range(1, 3)) begin
                    send_word(1'b0, CH_STAR, 1'b0, any_mode());
                    send_word(1'b0, CH_SLASH, 1'b0, any_mode());
                end
            end else if (roll < 80) begin
                send_word(1'b1, any_scalar(), any_flag(), any_mode());
            end
        end else begin
            // The first flag on a terminating line feed must be ignored.
            if (roll < 70) send_word(1'b0, CH_LF, any_flag(), any_mode());
            else if (roll < 90) send_word(1'b1, any_scalar(), any_flag(), any_mode());
        end
        // Otherwise the next comment restarts this one without a report.
    endtask

    // Broken openers, refused modes, stray end markers and idle scalars.
    task automatic send_noise();
        case ($urandom_range(0, 4))
            0: begin
                send_word(1'b0, CH_SLASH, 1'b1, 2'($urandom_range(0, 2)));
                send_word(1'b0, body_char(1'b1), 1'b0, any_mode());
            end
            1: send_word(1'b0, any_scalar(), 1'b1, MODE_NONE);
            2: send_word(1'b1, any_scalar(), any_flag(), any_mode());
            3: begin
                // Ignored by an idle scanner, so it does not count as work.
                send_word(1'b0, any_scalar(), 1'b0, any_mode());
                words_sent--;
            end
            default: begin
                send_word(1'b0, CH_SLASH, 1'b1, 2'($urandom_range(0, 2)));
                if ($urandom_range(0, 1)) send_word(1'b0, CH_SLASH, 1'b0, any_mode());
                send_word(1'b1, any_scalar(), 1'b0, any_mode());
            end
        endcase
    endtask

    // Receiver: random stall bursts, plus one long hold on request while the
    // sender keeps offering words, so the scanner backs up its input.
    initial begin : receiver
        int rx_stall;
        bit hold_served;
        rx_stall    = 0;
        hold_served = 1'b0;
        m_tready    = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_served) begin
                hold_served = 1'b1;
                rx_stall    = HOLD_CYCLES;
            end else if (rx_stall == 0 && idle_en && $urandom_range(0, 9) == 0) begin
                rx_stall = $urandom_range(1, 14);
            end
            if (rx_stall > 0) begin
                m_tready <= 1'b0;
                rx_stall--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: a run that has not finished by now has hung.
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("nested_comment_scanner_top regression: fail");
        $finish;
    end

    initial begin : stimulus
        i_rst_n  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Refused mode, then a scalar that an idle scanner ignores.
        send_word(1'b0, SCALAR_W'("x"), 1'b1, MODE_NONE);
        send_word(1'b0, 21'h10FFFF, 1'b0, MODE_DOC);
        // A lone slash is dropped by a restart; the plain line ends at a line
        // feed that carries first.
        send_word(1'b0, CH_SLASH, 1'b1, MODE_LINE);
        send_text("//", MODE_LINE);
        send_word(1'b0, '0, 1'b0, MODE_LINE);
        send_word(1'b0, CH_LF, 1'b1, MODE_BLOCK);
        // Line doc with a skipped space, ended by end of text with first set.
        send_text("/// x", MODE_DOC);
        send_word(1'b1, 21'h10FFFF, 1'b1, MODE_BLOCK);
        // Module doc with an empty body.
        send_text("//!\n", MODE_DOC);
        // Block that closes at depth one, then one that nests four deep and
        // is dropped by the restart that follows.
        send_text("/**/", MODE_BLOCK);
        send_text("/*/*/*/*", MODE_BLOCK);
        // Unterminated block, then end of text starting a scan on its own.
        send_text("/*", MODE_BLOCK);
        send_word(1'b1, '0, 1'b0, MODE_LINE);
        send_word(1'b1, '0, 1'b1, MODE_LINE);

        // Each refused word yields a report; the held receiver backs them up.
        hold_req <= 1'b1;
        repeat (16) send_word(1'b0, any_scalar(), 1'b1, MODE_NONE);

        words_sent = 0;
        send_random_comment(1'b1);
        while (words_sent < RANDOM_WORDS) begin
            if (words_sent >= RANDOM_WORDS - QUIET_TAIL) idle_en <= 1'b0;
            if ($urandom_range(0, 99) < 80) send_random_comment(1'b0);
            else send_noise();
        end
        s_tvalid <= 1'b0;

        while (pending_reports != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("nested_comment_scanner_top regression: pass");
        else
            $display("nested_comment_scanner_top regression: fail");
        $finish;
    end

endmodule

[nested_comment_scanner_top.f]
rtl/ncs_pkg.sv
rtl/ncs_in_reg.sv
rtl/ncs_core.sv
rtl/ncs_out_reg.sv
rtl/nested_comment_scanner_top.sv
dv/nested_comment_checker.sv
dv/tb_nested_comment_scanner_top.sv
